### rtl/core/pld_pkg.sv
// ---------------------------------------------------------------------------
// pld_pkg
// Types and constants for the point light diffuse pipeline: the configuration
// register indexes, the stage map and the payload record that moves through
// the stages.
// ---------------------------------------------------------------------------
package pld_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_LIGHT_X      = 3'd0;
    localparam logic [2:0] REG_LIGHT_Y      = 3'd1;
    localparam logic [2:0] REG_LIGHT_Z      = 3'd2;
    localparam logic [2:0] REG_LIGHT_COLOR  = 3'd3;
    localparam logic [2:0] REG_INNER_RADIUS = 3'd4;
    localparam logic [2:0] REG_OUTER_RADIUS = 3'd5;
    localparam logic [2:0] REG_ATTEN_MODE   = 3'd6;

    // Reset values
    localparam logic [47:0] COLOR_RST = 48'h0CCD_0CCD_0CCD;
    localparam logic [31:0] INNER_RST = 32'd6553600;
    localparam logic [31:0] OUTER_RST = 32'd65536000;

    // Q1.14 unity
    localparam logic [14:0] ONE_Q14 = 15'd16384;

    // Stage map
    localparam int ST_OFS  = 0;   // offset light - position
    localparam int ST_MAG  = 1;   // magnitudes
    localparam int ST_PRE  = 2;   // pre-scale shift
    localparam int ST_MUL  = 3;   // squares and dot-product terms
    localparam int ST_SUM  = 4;   // sums
    localparam int ST_SQ0  = 5;   // 32 square-root steps
    localparam int SQ_BITS = 32;
    localparam int ST_DST  = ST_SQ0 + SQ_BITS;   // distance, factor clamp
    localparam int ST_DV0  = ST_DST + 1;         // 15 factor divide steps
    localparam int Q_BITS  = 15;
    localparam int ST_ATN  = ST_DV0 + Q_BITS;    // factor, ramp decision, squares
    localparam int ST_NRM  = ST_ATN + 1;         // ramp operands, normalise
    localparam int ST_PRD  = ST_NRM + 1;         // ramp product
    localparam int ST_RD0  = ST_PRD + 1;         // 15 ramp divide steps
    localparam int ST_CHN  = ST_RD0 + Q_BITS;    // channel products
    localparam int ST_OUT  = ST_CHN + 1;         // saturating sums
    localparam int NUM_ST  = ST_OUT + 1;

    // Payload carried through every stage
    typedef struct packed {
        logic [2:0][32:0] d;
        logic [2:0][15:0] n;
        logic [2:0][15:0] acc;
        logic             last;
        logic [2:0]       neg_d;
        logic [2:0][32:0] ad;
        logic [1:0]       s;
        logic [2:0][30:0] a;
        logic [2:0][61:0] sqp;
        logic [2:0][47:0] nump;
        logic [63:0]      sq;
        logic [47:0]      num;
        logic             skip;
        logic [65:0]      rem;
        logic [31:0]      root;
        logic [31:0]      dlen;
        logic             sat;
        logic [14:0]      q;
        logic [14:0]      val;
        logic             beyond;
        logic             ramp;
        logic [63:0]      o2;
        logic [63:0]      i2;
        logic [63:0]      d2;
        logic [47:0]      nm;
        logic [47:0]      dn;
        logic [2:0][30:0] cp;
        logic [2:0][15:0] res;
        logic             lit;
    } pipe_t;

endpackage

### rtl/core/point_light_diffuse_attenuation.sv
// ---------------------------------------------------------------------------
// point_light_diffuse_attenuation
// Adds one point light's Lambert diffuse term, with optional linear or
// squared-distance attenuation, to a running vertex colour.
// ---------------------------------------------------------------------------
// The block takes one vertex per clock while s_ready is high and returns one
// result per vertex, in order. The pipeline depth is set by the 32 one-bit
// steps of the distance square root and the two 15-step quotient chains
// (normal factor and attenuation ramp). Every stage advances together
// whenever the output register is empty or being taken, so s_ready drops
// only while a finished result waits. Light registers are sampled live by
// the stages and must only be written while no vertex is in flight.
module point_light_diffuse_attenuation
    import pld_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_wdata,
    // vertex in
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_pos_x,
    input  logic [31:0] s_pos_y,
    input  logic [31:0] s_pos_z,
    input  logic [15:0] s_norm_x,
    input  logic [15:0] s_norm_y,
    input  logic [15:0] s_norm_z,
    input  logic [15:0] s_acc_r,
    input  logic [15:0] s_acc_g,
    input  logic [15:0] s_acc_b,
    input  logic        s_last_vertex,
    // result out
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_out_r,
    output logic [15:0] m_out_g,
    output logic [15:0] m_out_b,
    output logic        m_lit,
    output logic        m_last_out
);

    logic [31:0] light_x_reg, light_y_reg, light_z_reg;
    logic [47:0] light_color_reg;
    logic [31:0] inner_radius_reg, outer_radius_reg;
    logic [1:0]  atten_mode_reg;

    pipe_t       pl_reg  [NUM_ST];
    pipe_t       pl_next [NUM_ST];
    logic [NUM_ST-1:0] vld_reg;
    logic        adv;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_x_reg      <= '0;
            light_y_reg      <= '0;
            light_z_reg      <= '0;
            light_color_reg  <= COLOR_RST;
            inner_radius_reg <= INNER_RST;
            outer_radius_reg <= OUTER_RST;
            atten_mode_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LIGHT_X:      light_x_reg      <= cfg_wdata[31:0];
                REG_LIGHT_Y:      light_y_reg      <= cfg_wdata[31:0];
                REG_LIGHT_Z:      light_z_reg      <= cfg_wdata[31:0];
                REG_LIGHT_COLOR:  light_color_reg  <= cfg_wdata;
                REG_INNER_RADIUS: inner_radius_reg <= cfg_wdata[31:0];
                REG_OUTER_RADIUS: outer_radius_reg <= cfg_wdata[31:0];
                REG_ATTEN_MODE:   atten_mode_reg   <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // whole pipe moves unless a finished result is held
    assign adv     = !vld_reg[NUM_ST-1] || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NUM_ST-2:0], s_valid};
        end
    end

    // offset from vertex to light, exact in 33 bits
    always_comb begin
        pl_next[ST_OFS]      = '0;
        pl_next[ST_OFS].d[0] = {light_x_reg[31], light_x_reg} - {s_pos_x[31], s_pos_x};
        pl_next[ST_OFS].d[1] = {light_y_reg[31], light_y_reg} - {s_pos_y[31], s_pos_y};
        pl_next[ST_OFS].d[2] = {light_z_reg[31], light_z_reg} - {s_pos_z[31], s_pos_z};
        pl_next[ST_OFS].n    = {s_norm_z, s_norm_y, s_norm_x};
        pl_next[ST_OFS].acc  = {s_acc_b, s_acc_g, s_acc_r};
        pl_next[ST_OFS].last = s_last_vertex;
    end

    for (genvar k = 1; k < NUM_ST; k++) begin : g_st
        if (k == ST_MAG) begin : g_mag
            // component magnitudes
            always_comb begin
                pl_next[k] = pl_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    pl_next[k].neg_d[i] = pl_reg[k-1].d[i][32];
                    pl_next[k].ad[i]    = pl_reg[k-1].d[i][32] ?
                                          33'(-pl_reg[k-1].d[i]) : pl_reg[k-1].d[i];
                end
            end
        end else if (k == ST_PRE) begin : g_pre
            // pre-scale so that every magnitude is below 2^31
            logic [32:0] m;
            always_comb begin
                pl_next[k] = pl_reg[k-1];
                m = pl_reg[k-1].ad[0];
                if (pl_reg[k-1].ad[1] > m) m = pl_reg[k-1].ad[1];
                if (pl_reg[k-1].ad[2] > m) m = pl_reg[k-1].ad[2];
                pl_next[k].s = m[32] ? 2'd2 : (m[31] ? 2'd1 : 2'd0);
                for (int i = 0; i < 3; i++) begin
                    pl_next[k].a[i] = 31'(pl_reg[k-1].ad[i] >> pl_next[k].s);
                end
            end
        end else if (k == ST_MUL) begin : g_mul
            // squares and signed dot-product terms
            logic signed [47:0] ds, nn;
            always_comb begin
                pl_next[k] = pl_reg[k-1];
                ds = '0;
                nn = '0;
                for (int i = 0; i < 3; i++) begin
                    pl_next[k].sqp[i] = 62'(pl_reg[k-1].a[i]) * 62'(pl_reg[k-1].a[i]);
                    ds = pl_reg[k-1].neg_d[i] ? -$signed({17'd0, pl_reg[k-1].a[i]})
                                              :  $signed({17'd0, pl_reg[k-1].a[i]});
                    nn = $signed({{32{pl_reg[k-1].n[i][15]}}, pl_reg[k-1].n[i]});
                    pl_next[k].nump[i] = 48'(ds * nn);
                end
            end
        end else if (k == ST_SUM) begin : g_sum
            // length squared and dot product; one guard bit keeps the sign
            logic [48:0] ns;
            always_comb begin
                pl_next[k] = pl_reg[k-1];
                pl_next[k].sq = 64'(pl_reg[k-1].sqp[0]) + 64'(pl_reg[k-1].sqp[1])
                              + 64'(pl_reg[k-1].sqp[2]);
                ns = {pl_reg[k-1].nump[0][47], pl_reg[k-1].nump[0]}
                   + {pl_reg[k-1].nump[1][47], pl_reg[k-1].nump[1]}
                   + {pl_reg[k-1].nump[2][47], pl_reg[k-1].nump[2]};
                pl_next[k].num  = ns[47:0];
                pl_next[k].skip = (pl_next[k].sq == 64'd0) || ns[48];
                pl_next[k].rem  = {2'b00, pl_next[k].sq};
                pl_next[k].root = '0;
            end
        end else if (k >= ST_SQ0 && k < ST_SQ0 + SQ_BITS) begin : g_sq
            // one result bit of the square root
            localparam int B = SQ_BITS - 1 - (k - ST_SQ0);
            logic [65:0] trial;
            always_comb begin
                pl_next[k] = pl_reg[k-1];
                trial = ({34'd0, pl_reg[k-1].root} << (B + 1)) + (66'd1 << (2 * B));
                if (pl_reg[k-1].rem >= trial) begin
                    pl_next[k].rem     = pl_reg[k-1].rem - trial;
                    pl_next[k].root[B] = 1'b1;
                end
            end
        end else if (k == ST_DST) begin : g_dst
            // distance and clamp test for a factor above one
            logic [33:0] rs;
            logic [46:0] thr;
            always_comb begin
                pl_next[k] = pl_reg[k-1];
                rs  = {2'b00, pl_reg[k-1].root} << pl_reg[k-1].s;
                pl_next[k].dlen = (rs[33:32] != 2'b00) ? '1 : rs[31:0];
                thr = {1'b0, pl_reg[k-1].root, 14'd0} + 47'(pl_reg[k-1].root);
                pl_next[k].sat = pl_reg[k-1].num >= {1'b0, thr};
                pl_next[k].rem = {18'd0, pl_reg[k-1].num};
                pl_next[k].q   = '0;
            end
        end else if (k >= ST_DV0 && k < ST_DV0 + Q_BITS) begin : g_dv
            // one quotient bit of dot / length
            localparam int B = Q_BITS - 1 - (k - ST_DV0);
            logic [47:0] dv;
            always_comb begin
                pl_next[k] = pl_reg[k-1];
                dv = {16'd0, pl_reg[k-1].root} << B;
                if (pl_reg[k-1].rem[47:0] >= dv) begin
                    pl_next[k].rem  = {18'd0, pl_reg[k-1].rem[47:0] - dv};
                    pl_next[k].q[B] = 1'b1;
                end
            end
        end else if (k == ST_ATN) begin : g_atn
            // factor, radius tests and squared radii
            always_comb begin
                pl_next[k] = pl_reg[k-1];
                pl_next[k].val    = pl_reg[k-1].sat ? ONE_Q14 : pl_reg[k-1].q;
                pl_next[k].beyond = atten_mode_reg[0] &&
                                    (pl_reg[k-1].dlen > outer_radius_reg);
                pl_next[k].ramp   = atten_mode_reg[0] &&
                                    (pl_reg[k-1].dlen <= outer_radius_reg) &&
                                    (pl_reg[k-1].dlen > inner_radius_reg);
                pl_next[k].o2 = 64'(outer_radius_reg) * 64'(outer_radius_reg);
                pl_next[k].i2 = 64'(inner_radius_reg) * 64'(inner_radius_reg);
                pl_next[k].d2 = 64'(pl_reg[k-1].dlen) * 64'(pl_reg[k-1].dlen);
            end
        end else if (k == ST_NRM) begin : g_nrm
            // ramp operands, squared ones scaled until the divisor fits 48 bits
            logic [63:0] nm0, dn0;
            logic [4:0]  sh;
            always_comb begin
                pl_next[k] = pl_reg[k-1];
                nm0 = pl_reg[k-1].o2 - pl_reg[k-1].d2;
                dn0 = pl_reg[k-1].o2 - pl_reg[k-1].i2;
                sh  = '0;
                for (int i = 0; i < 16; i++) begin
                    if (dn0[48 + i]) sh = 5'(i + 1);
                end
                if (atten_mode_reg[1]) begin
                    pl_next[k].nm = 48'(nm0 >> sh);
                    pl_next[k].dn = 48'(dn0 >> sh);
                end else begin
                    pl_next[k].nm = {16'd0, outer_radius_reg - pl_reg[k-1].dlen};
                    pl_next[k].dn = {16'd0, outer_radius_reg - inner_radius_reg};
                end
            end
        end else if (k == ST_PRD) begin : g_prd
            // ramp numerator
            always_comb begin
                pl_next[k] = pl_reg[k-1];
                pl_next[k].rem = {3'd0, 63'(pl_reg[k-1].val) * 63'(pl_reg[k-1].nm)};
                pl_next[k].q   = '0;
            end
        end else if (k >= ST_RD0 && k < ST_RD0 + Q_BITS) begin : g_rd
            // one quotient bit of the ramp
            localparam int B = Q_BITS - 1 - (k - ST_RD0);
            logic [62:0] dv;
            always_comb begin
                pl_next[k] = pl_reg[k-1];
                dv = {15'd0, pl_reg[k-1].dn} << B;
                if (pl_reg[k-1].rem[62:0] >= dv) begin
                    pl_next[k].rem  = {3'd0, pl_reg[k-1].rem[62:0] - dv};
                    pl_next[k].q[B] = 1'b1;
                end
            end
        end else if (k == ST_CHN) begin : g_chn
            // per-channel light contribution
            logic [14:0] v;
            always_comb begin
                pl_next[k] = pl_reg[k-1];
                v = pl_reg[k-1].ramp ? pl_reg[k-1].q : pl_reg[k-1].val;
                pl_next[k].val = v;
                for (int i = 0; i < 3; i++) begin
                    pl_next[k].cp[i] = 31'(light_color_reg[32 - 16 * i +: 16]) * 31'(v);
                end
            end
        end else begin : g_out
            // saturating sums, unlit vertices pass their colour through
            logic [17:0] sum;
            always_comb begin
                pl_next[k] = pl_reg[k-1];
                pl_next[k].lit = !pl_reg[k-1].skip && !pl_reg[k-1].beyond;
                sum = '0;
                for (int i = 0; i < 3; i++) begin
                    sum = {2'b00, pl_reg[k-1].acc[i]} + {1'b0, pl_reg[k-1].cp[i][30:14]};
                    if (!pl_next[k].lit) begin
                        pl_next[k].res[i] = pl_reg[k-1].acc[i];
                    end else if (sum[17:16] != 2'b00) begin
                        pl_next[k].res[i] = '1;
                    end else begin
                        pl_next[k].res[i] = sum[15:0];
                    end
                end
            end
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NUM_ST; k++) begin
                pl_reg[k] <= pl_next[k];
            end
        end
    end

    assign m_valid    = vld_reg[NUM_ST-1];
    assign m_out_r    = pl_reg[NUM_ST-1].res[0];
    assign m_out_g    = pl_reg[NUM_ST-1].res[1];
    assign m_out_b    = pl_reg[NUM_ST-1].res[2];
    assign m_lit      = pl_reg[NUM_ST-1].lit;
    assign m_last_out = pl_reg[NUM_ST-1].last;

endmodule
